// File: sv/console_io_port_mapper_defines.svh
// Assertion macros for the console I/O port mapper.
`ifndef CONSOLE_IO_PORT_MAPPER_DEFINES_SVH
`define CONSOLE_IO_PORT_MAPPER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cmp_pkg.sv
// Shared codes and constants for the console I/O port mapper.
package cmp_pkg;

  typedef logic [2:0] route_t;
  typedef logic [1:0] req_kind_t;

  // Request kinds
  localparam req_kind_t REQ_READ   = 2'd0;
  localparam req_kind_t REQ_WRITE  = 2'd1;
  localparam req_kind_t REQ_UPDATE = 2'd2;

  // Route codes
  localparam route_t ROUTE_INTERNAL    = 3'd0;
  localparam route_t ROUTE_SND_WR      = 3'd1;
  localparam route_t ROUTE_VID_CTRL_WR = 3'd2;
  localparam route_t ROUTE_VID_DATA_WR = 3'd3;
  localparam route_t ROUTE_VCOUNT_RD   = 3'd4;
  localparam route_t ROUTE_VID_STAT_RD = 3'd5;
  localparam route_t ROUTE_VID_DATA_RD = 3'd6;

  // Port address bank, taken from address bits 7:6
  localparam logic [1:0] BANK_CTRL  = 2'd0;
  localparam logic [1:0] BANK_SOUND = 2'd1;
  localparam logic [1:0] BANK_VIDEO = 2'd2;
  localparam logic [1:0] BANK_PADS  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_INPUT_MODE    = 1'b0;
  localparam logic CFG_EXPORT_REGION = 1'b1;

  localparam logic [7:0] MEM_CTRL_PORT  = 8'h3E;
  localparam logic [7:0] MEM_CTRL_RESET = 8'hA4;
  localparam logic [7:0] PAD_RESET      = 8'hFF;
  localparam logic [7:0] HCOUNT_VALUE   = 8'hFF;
  localparam logic [7:0] PAD_KEEP_LOW   = 8'h3F;
  localparam logic [7:0] NIBBLE_HI_MASK = 8'hF0;
  localparam logic [7:0] NIBBLE_LO_MASK = 8'hD0;
  localparam logic [7:0] NIBBLE_HI_FLAG = 8'h20;

endpackage

// File: sv/cmp_req_if.sv
// Request channel: one bus access or controller update per word.
interface cmp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] port_addr;
  logic [7:0] write_value;
  logic [7:0] pad_one_bits;
  logic [7:0] pad_two_bits;
  logic [7:0] paddle_position;

  modport source (
    output valid, req_type, port_addr, write_value, pad_one_bits, pad_two_bits,
           paddle_position,
    input  ready
  );
  modport sink (
    input  valid, req_type, port_addr, write_value, pad_one_bits, pad_two_bits,
           paddle_position,
    output ready
  );
endinterface

// File: sv/cmp_res_if.sv
// Result channel: decoded outcome of one request per word.
interface cmp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [2:0] route;
  logic [7:0] route_value;
  logic [7:0] mem_control;

  modport source (
    output valid, read_data, route, route_value, mem_control,
    input  ready
  );
  modport sink (
    input  valid, read_data, route, route_value, mem_control,
    output ready
  );
endinterface

// File: sv/console_io_port_mapper.sv
// Console I/O port mapper: decodes CPU port accesses and keeps pad/control state.
//
// Usage:
//   req carries one word per CPU port read, port write or controller update.
//   res returns exactly one word per request, in order: read_data for reads
//   served here, a route code and route_value for sound/video accesses, and
//   the memory control register as it stands after the request.
//   cfg_we/cfg_index/cfg_data write input_mode (index 0) and export_region
//   (index 1); write them only while no request is in flight.
// Timing:
//   One request per cycle sustained while res keeps draining. Each request
//   is decoded in the cycle it is accepted and its result sits in the
//   output register the next cycle. State updates happen at acceptance.
// Reset (rst, synchronous): output register empties, pads read 0xFF, memory
//   control 0xA4, paddle position and nibble flip-flop 0, joypad mode, export.
// Stall: while res is held off with a word waiting, req.ready drops; it is
//   high whenever the output register is empty or being drained.
`include "console_io_port_mapper_defines.svh"

module console_io_port_mapper
  import cmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_data,
  cmp_req_if.sink   req,
  cmp_res_if.source res
);

  logic       input_mode;
  logic       export_region;
  logic [7:0] memory_control;
  logic [7:0] pad_one;
  logic [7:0] pad_two;
  logic [7:0] paddle_pos;
  logic       nibble_toggle;

  logic [7:0] memory_control_next;
  logic [7:0] pad_one_next;
  logic [7:0] pad_two_next;
  logic [7:0] paddle_pos_next;
  logic       nibble_toggle_next;
  logic [7:0] read_data_next;
  route_t     route_next;
  logic [7:0] route_value_next;

  logic       accept;
  logic [1:0] bank;
  logic       odd_port;

  assign req.ready = !res.valid || res.ready;
  assign accept    = req.valid && req.ready;
  assign bank      = req.port_addr[7:6];
  assign odd_port  = req.port_addr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      input_mode    <= 1'b0;
      export_region <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_MODE:    input_mode    <= cfg_data;
        CFG_EXPORT_REGION: export_region <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    memory_control_next = memory_control;
    pad_one_next        = pad_one;
    pad_two_next        = pad_two;
    paddle_pos_next     = paddle_pos;
    nibble_toggle_next  = nibble_toggle;
    read_data_next      = 8'h00;
    route_next          = ROUTE_INTERNAL;
    route_value_next    = 8'h00;

    case (req.req_type)
      REQ_READ: begin
        unique case (bank)
          BANK_CTRL: begin
            read_data_next = (req.port_addr == MEM_CTRL_PORT) ? memory_control
                                                              : req.port_addr;
          end
          BANK_SOUND: begin
            if (odd_port) read_data_next = HCOUNT_VALUE;
            else          route_next     = ROUTE_VCOUNT_RD;
          end
          BANK_VIDEO: begin
            route_next = odd_port ? ROUTE_VID_STAT_RD : ROUTE_VID_DATA_RD;
          end
          BANK_PADS: begin
            if (odd_port) begin
              read_data_next = pad_two;
            end else begin
              // Paddle: alternate high/low nibble, bit 5 flags the high one.
              if (input_mode) begin
                nibble_toggle_next = !nibble_toggle;
                if (!nibble_toggle) begin
                  pad_one_next = ((pad_one | NIBBLE_HI_FLAG) & NIBBLE_HI_MASK)
                               | {4'h0, paddle_pos[7:4]};
                end else begin
                  pad_one_next = (pad_one & NIBBLE_LO_MASK) | {4'h0, paddle_pos[3:0]};
                end
              end
              read_data_next = pad_one_next;
            end
          end
          default: ;
        endcase
      end
      REQ_WRITE: begin
        unique case (bank)
          BANK_CTRL: begin
            if (!odd_port) begin
              memory_control_next = req.write_value;
            end else if (req.write_value[0] && req.write_value[2]) begin
              // Control port write with TH pins as outputs: region bits to pad 2.
              pad_two_next = pad_two & PAD_KEEP_LOW;
              if (export_region) begin
                pad_two_next[7] = req.write_value[7];
                pad_two_next[6] = req.write_value[5];
              end
            end
          end
          BANK_SOUND: begin
            route_next       = ROUTE_SND_WR;
            route_value_next = req.write_value;
          end
          BANK_VIDEO: begin
            route_next       = odd_port ? ROUTE_VID_CTRL_WR : ROUTE_VID_DATA_WR;
            route_value_next = req.write_value;
          end
          BANK_PADS: ;
          default: ;
        endcase
      end
      REQ_UPDATE: begin
        pad_one_next    = req.pad_one_bits;
        pad_two_next    = req.pad_two_bits;
        paddle_pos_next = req.paddle_position;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_control <= MEM_CTRL_RESET;
      pad_one        <= PAD_RESET;
      pad_two        <= PAD_RESET;
      paddle_pos     <= 8'h00;
      nibble_toggle  <= 1'b0;
      res.valid      <= 1'b0;
    end else begin
      if (accept) begin
        memory_control <= memory_control_next;
        pad_one        <= pad_one_next;
        pad_two        <= pad_two_next;
        paddle_pos     <= paddle_pos_next;
        nibble_toggle  <= nibble_toggle_next;
        res.valid      <= 1'b1;
      end else if (res.ready) begin
        res.valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.read_data   <= read_data_next;
      res.route       <= route_next;
      res.route_value <= route_value_next;
      res.mem_control <= memory_control_next;
    end
  end

  `CMP_ASSERT_NOW(a_internal_no_fwd,
    res.valid && res.route == ROUTE_INTERNAL, res.route_value == 8'h00,
    "internal result carries a forwarded byte")

  `CMP_ASSERT_NOW(a_routed_rd_no_data,
    res.valid && (res.route == ROUTE_VCOUNT_RD || res.route == ROUTE_VID_STAT_RD ||
                  res.route == ROUTE_VID_DATA_RD),
    res.read_data == 8'h00,
    "routed read returned data")

  `CMP_ASSERT_NEXT(a_domestic_region,
    accept && req.req_type == REQ_WRITE && bank == BANK_CTRL && odd_port &&
      req.write_value[0] && req.write_value[2] && !export_region,
    pad_two[7:6] == 2'b00,
    "domestic region copy left pad 2 bits set")

  `CMP_ASSERT_NEXT(a_joypad_no_toggle,
    accept && !input_mode && !cfg_we, $stable(nibble_toggle),
    "nibble flip-flop moved in joypad mode")

endmodule
